### rtl/core/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg : shared types and constants of the 32-bit xxHash stream hasher
// The five hash primes, the rotate helper and the request structures that
// pass between the sequencer, the shared multiplier and the block buffer.
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [31:0] PRIME1 = 32'h9e37_79b1;
  localparam logic [31:0] PRIME2 = 32'h85eb_ca77;
  localparam logic [31:0] PRIME3 = 32'hc2b2_ae3d;
  localparam logic [31:0] PRIME4 = 32'h27d4_eb2f;
  localparam logic [31:0] PRIME5 = 32'h1656_67b1;

  // Multiply request: the product register loads only when en is high.
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } xxh_mreq_t;

  // Byte write into the block buffer, which is held as four 32-bit words.
  typedef struct packed {
    logic       en;
    logic [1:0] word;
    logic [1:0] lane;
    logic [7:0] data;
  } xxh_bwr_t;

  // Left rotate by a constant amount between 1 and 31.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

endpackage

### rtl/core/xxhash32_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// xxhash32_stream_hasher_top : 32-bit xxHash of a byte stream
// A byte that does not complete a block is simply stored; the byte that
//   completes a 16-byte block starts a compression of 4 lanes x 5 steps.
// A last transaction adds the finalisation: the lane sum when 16 bytes or
//   more were seen, a round per tail word and per tail byte, the avalanche.
// The single shared multiplier, used twice per round, sets the pace.
// Reset (synchronous, active high) clears the seed to zero and starts a new
//   message; the result channel comes out of reset empty.
// ----------------------------------------------------------------------------
module xxhash32_stream_hasher_top
  import xxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input channel: at most one message byte per transaction.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  // Result channel: one digest per message.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The sequencer walks through these steps. Each hash round is split into
  // five: fetch the word, multiply it by a prime, add it into the
  // accumulator, multiply the rotated accumulator, write back.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CRD, S_CM1, S_CADD, S_CM2, S_CWB,
    S_FINIT, S_FSUM, S_FLEN,
    S_TRD, S_TM1, S_TADD, S_TM2, S_TWB,
    S_AV1, S_AV2, S_AV3, S_AV4, S_AV5
  } state_t;

  localparam logic [1:0] REG_SEED = 2'd0;

  state_t      state;
  logic [31:0] seed;
  logic [31:0] lanes [4];
  logic [1:0]  lane_idx;
  logic [31:0] h;
  logic [3:0]  fill;
  logic [3:0]  pos;
  logic [3:0]  left;
  logic [31:0] msg_len;
  logic        long_msg;
  logic        pend_last;

  logic        in_acc;
  logic        cfg_wr;
  logic        out_free;
  logic        tail_word;
  logic [3:0]  tail_step;
  logic [3:0]  left_next;
  logic [31:0] msg_len_next;
  logic [31:0] lane_rot;
  logic [7:0]  tail_byte;

  xxh_mreq_t   mreq;
  logic [31:0] prod;
  xxh_bwr_t    bwr;
  logic [1:0]  raddr;
  logic [31:0] rdata;

  xxh_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  xxh_buf u_buf (
    .clk   (clk),
    .wr    (bwr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // Handshakes. Input is only taken while the sequencer rests; a finished
  // digest sits in the output register and does not hold up new bytes.
  // --------------------------------------------------------------------------
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr == REG_SEED);
  assign out_free  = !out_valid || !out_stall;
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_SEED) ? seed : 32'd0;

  assign msg_len_next = msg_len + 32'd1;

  // Tail handling consumes whole words while four or more bytes remain,
  // then single bytes.
  assign tail_word = (left[3:2] != 2'b00);
  assign tail_step = tail_word ? 4'd4 : 4'd1;
  assign left_next = left - tail_step;
  assign tail_byte = rdata[{pos[1:0], 3'b000} +: 8];

  // Lane rotations for the convergence sum of a long message.
  always_comb begin
    unique case (lane_idx)
      2'd0:    lane_rot = rotl32(lanes[0], 1);
      2'd1:    lane_rot = rotl32(lanes[1], 7);
      2'd2:    lane_rot = rotl32(lanes[2], 12);
      default: lane_rot = rotl32(lanes[3], 18);
    endcase
  end

  // Byte write: the incoming byte lands at the current fill position.
  always_comb begin
    bwr.en   = in_acc && has_byte;
    bwr.word = fill[3:2];
    bwr.lane = fill[1:0];
    bwr.data = data_byte;
  end

  // Buffer read address: the lane word during compression, the tail word
  // that holds the next byte or word during finalisation.
  assign raddr = (state == S_CRD) ? lane_idx : pos[3:2];

  // Operand selection for the shared multiplier.
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = h;
    mreq.b  = PRIME3;
    unique case (state)
      S_CM1: begin
        mreq.en = 1'b1;
        mreq.a  = rdata;
        mreq.b  = PRIME2;
      end
      S_CM2: begin
        mreq.en = 1'b1;
        mreq.a  = rotl32(lanes[lane_idx], 13);
        mreq.b  = PRIME1;
      end
      S_TM1: begin
        mreq.en = 1'b1;
        mreq.a  = tail_word ? rdata : {24'd0, tail_byte};
        mreq.b  = tail_word ? PRIME3 : PRIME5;
      end
      S_TM2: begin
        mreq.en = 1'b1;
        mreq.a  = tail_word ? rotl32(h, 17) : rotl32(h, 11);
        mreq.b  = tail_word ? PRIME4 : PRIME1;
      end
      S_AV2: begin
        mreq.en = 1'b1;
        mreq.b  = PRIME2;
      end
      S_AV4: begin
        mreq.en = 1'b1;
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, message state and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seed      <= 32'd0;
      lanes[0]  <= PRIME1 + PRIME2;
      lanes[1]  <= PRIME2;
      lanes[2]  <= 32'd0;
      lanes[3]  <= 32'd0 - PRIME1;
      lane_idx  <= 2'd0;
      fill      <= 4'd0;
      pos       <= 4'd0;
      left      <= 4'd0;
      msg_len   <= 32'd0;
      long_msg  <= 1'b0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The final step reloads the output register itself when it is free.
      if (out_valid && !out_stall && (cfg_wr || state != S_AV5)) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr) begin
        // A new seed abandons any message in progress.
        seed     <= pwdata;
        lanes[0] <= pwdata + PRIME1 + PRIME2;
        lanes[1] <= pwdata + PRIME2;
        lanes[2] <= pwdata;
        lanes[3] <= pwdata - PRIME1;
        fill     <= 4'd0;
        msg_len  <= 32'd0;
        long_msg <= 1'b0;
        state    <= S_IDLE;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (in_acc) begin
              if (has_byte) begin
                fill    <= fill + 4'd1;
                msg_len <= msg_len_next;
                if (msg_len_next == 32'd16) begin
                  long_msg <= 1'b1;
                end
              end
              pend_last <= last;
              lane_idx  <= 2'd0;
              if (has_byte && fill == 4'd15) begin
                state <= S_CRD;
              end else if (last) begin
                state <= S_FINIT;
              end
            end
          end

          S_CRD:  state <= S_CM1;
          S_CM1:  state <= S_CADD;
          S_CADD: begin
            lanes[lane_idx] <= lanes[lane_idx] + prod;
            state           <= S_CM2;
          end
          S_CM2:  state <= S_CWB;
          S_CWB: begin
            lanes[lane_idx] <= prod;
            lane_idx        <= lane_idx + 2'd1;
            if (lane_idx != 2'd3) begin
              state <= S_CRD;
            end else if (pend_last) begin
              state <= S_FINIT;
            end else begin
              state <= S_IDLE;
            end
          end

          S_FINIT: begin
            h        <= long_msg ? 32'd0 : seed + PRIME5;
            lane_idx <= 2'd0;
            left     <= fill;
            pos      <= 4'd0;
            state    <= long_msg ? S_FSUM : S_FLEN;
          end
          S_FSUM: begin
            h        <= h + lane_rot;
            lane_idx <= lane_idx + 2'd1;
            if (lane_idx == 2'd3) begin
              state <= S_FLEN;
            end
          end
          S_FLEN: begin
            h     <= h + msg_len;
            state <= (left != 4'd0) ? S_TRD : S_AV1;
          end

          S_TRD:  state <= S_TM1;
          S_TM1:  state <= S_TADD;
          S_TADD: begin
            h     <= h + prod;
            state <= S_TM2;
          end
          S_TM2:  state <= S_TWB;
          S_TWB: begin
            h     <= prod;
            pos   <= pos + tail_step;
            left  <= left_next;
            state <= (left_next != 4'd0) ? S_TRD : S_AV1;
          end

          S_AV1: begin
            h     <= h ^ (h >> 15);
            state <= S_AV2;
          end
          S_AV2:  state <= S_AV3;
          S_AV3: begin
            h     <= prod ^ (prod >> 13);
            state <= S_AV4;
          end
          S_AV4:  state <= S_AV5;
          S_AV5: begin
            // Wait here until the output register is free; the product
            // register holds meanwhile.
            if (out_free) begin
              hash_value <= prod ^ (prod >> 16);
              out_valid  <= 1'b1;
              lanes[0]   <= seed + PRIME1 + PRIME2;
              lanes[1]   <= seed + PRIME2;
              lanes[2]   <= seed;
              lanes[3]   <= seed - PRIME1;
              fill       <= 4'd0;
              msg_len    <= 32'd0;
              long_msg   <= 1'b0;
              state      <= S_IDLE;
            end
          end

          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The byte that fills the buffer must start a block compression.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && has_byte && fill == 4'd15 && !cfg_wr) |=> (state == S_CRD))
    else $error("full block did not start compression");

  // After the last lane of a block the buffer is empty again.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CWB && lane_idx == 2'd3 && !cfg_wr) |=> (fill == 4'd0))
    else $error("block buffer not empty after compression");

  // Tail bookkeeping: consumed plus remaining bytes always equal the fill.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_TRD || state == S_TM1 || state == S_TADD ||
     state == S_TM2 || state == S_TWB) |-> (4'(pos + left) == fill))
    else $error("tail position and count disagree with fill");

  // A digest appears only from the last avalanche step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_AV5))
    else $error("result produced outside the final step");

endmodule

### rtl/core/xxh_mul.sv
// ----------------------------------------------------------------------------
// xxh_mul : shared 32 x 32 multiplier
// Keeps the low 32 bits of the product in a register, loaded on request.
// ----------------------------------------------------------------------------
module xxh_mul
  import xxh_pkg::*;
(
  input  logic        clk,
  input  xxh_mreq_t   req,
  output logic [31:0] prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

### rtl/core/xxh_buf.sv
// ----------------------------------------------------------------------------
// xxh_buf : 16-byte block buffer
// Four little-endian words with byte-wide writes and a registered word read.
// ----------------------------------------------------------------------------
module xxh_buf
  import xxh_pkg::*;
(
  input  logic        clk,
  input  xxh_bwr_t    wr,
  input  logic [1:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [4];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.word][{wr.lane, 3'b000} +: 8] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the 32-bit xxHash stream hasher
// Byte messages of mixed length are streamed in under several idling
// patterns. The seed register is programmed between phases and read back.
// Every digest is checked against a behavioural model of the hash that
// the bench keeps for itself.
// ----------------------------------------------------------------------------
module tb_top
  import xxh_pkg::*;
();

  // Byte address of the seed register on the configuration port.
  localparam logic [1:0] SEED_ADDR = 2'd0;
  // This margin covers a block compression or a finalisation still in flight.
  localparam int SETTLE_CYCLES = 80;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int QUIET_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES = 4;
  localparam int MAX_REPORTS = 10;

  // --------------------------------------------------------------------------
  // Behavioural model of the hash. It mirrors the streaming state of the
  // block and holds the digests that are due on the result channel.
  // --------------------------------------------------------------------------
  class xxh_digest_scoreboard;
    bit [31:0] seed_reg;
    bit [31:0] lane [4];
    bit [7:0]  block_bytes [16];
    int        fill;
    bit [31:0] msg_len;
    bit        long_msg;
    bit [31:0] expected_digests [$];
    int        errors;

    function new();
      seed_reg = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      lane[0]  = seed_reg + PRIME1 + PRIME2;
      lane[1]  = seed_reg + PRIME2;
      lane[2]  = seed_reg;
      lane[3]  = seed_reg - PRIME1;
      fill     = 0;
      msg_len  = '0;
      long_msg = 1'b0;
      foreach (block_bytes[i]) block_bytes[i] = '0;
    endfunction

    function bit [31:0] rotl(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // Words in the block buffer are little-endian.
    function bit [31:0] word_at(int base);
      return {block_bytes[base + 3], block_bytes[base + 2],
              block_bytes[base + 1], block_bytes[base]};
    endfunction

    function void compress();
      bit [31:0] acc;
      for (int i = 0; i < 4; i++) begin
        acc = lane[i] + word_at(4 * i) * PRIME2;
        lane[i] = rotl(acc, 13) * PRIME1;
      end
    endfunction

    function bit [31:0] digest();
      bit [31:0] h;
      int pos;
      int left;
      pos = 0;
      left = fill;
      if (long_msg) begin
        h = rotl(lane[0], 1) + rotl(lane[1], 7) + rotl(lane[2], 12) + rotl(lane[3], 18);
      end else begin
        h = seed_reg + PRIME5;
      end
      h = h + msg_len;
      while (left >= 4) begin
        h = h + word_at(pos) * PRIME3;
        h = rotl(h, 17) * PRIME4;
        pos += 4;
        left -= 4;
      end
      while (left > 0) begin
        h = h + {24'd0, block_bytes[pos]} * PRIME5;
        h = rotl(h, 11) * PRIME1;
        pos++;
        left--;
      end
      h = h ^ (h >> 15);
      h = h * PRIME2;
      h = h ^ (h >> 13);
      h = h * PRIME3;
      h = h ^ (h >> 16);
      return h;
    endfunction

    // A seed write abandons any message in progress.
    function void load_seed(bit [31:0] value);
      seed_reg = value;
      restart();
    endfunction

    function void note_item(bit [7:0] data, bit has, bit is_last);
      if (has) begin
        block_bytes[fill] = data;
        fill++;
        msg_len = msg_len + 1;
        if (msg_len == 32'd16) long_msg = 1'b1;
        if (fill == 16) begin
          compress();
          fill = 0;
        end
      end
      if (is_last) begin
        expected_digests.push_back(digest());
        restart();
      end
    endfunction

    function void flag(string what, bit [31:0] exp_v, bit [31:0] act_v);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s: expected %08h, got %08h", $realtime, what, exp_v, act_v);
      end
    endfunction

    function void check_digest(bit [31:0] actual);
      bit [31:0] exp_v;
      if (expected_digests.size() == 0) begin
        flag("unexpected digest", '0, actual);
      end else begin
        exp_v = expected_digests.pop_front();
        if (exp_v !== actual) flag("digest mismatch", exp_v, actual);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] hash_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = SEED_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  xxh_digest_scoreboard sb = new();

  // Idle percentages for the sender and the receiver in the current phase.
  int src_pct = 0;
  int sink_pct = 0;
  int msg_src_pct = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  xxhash32_stream_hasher_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random, but every fourth window is left clear
  // so that the result channel also sees unbroken stretches.
  initial begin : receiver
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      out_stall <= (((cyc / 128) % 4) != 0) && ($urandom_range(99) < sink_pct);
      cyc++;
    end
  end

  // Transactions are observed at the rising edge, where the outputs still
  // hold the values that the edge itself samples.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) sb.note_item(data_byte, has_byte, last);
      if (out_valid && !out_stall) sb.check_digest(hash_value);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // The run is abandoned when neither channel has moved for too long.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("xxhash32_stream_hasher_top test failed");
    $finish;
  end

  // Presents one input transaction and returns at the falling edge after it
  // was accepted, with valid still high, so that the next call can either
  // present its own transaction or lower valid for a gap.
  task automatic send_item(input logic [7:0] data, input logic has, input logic is_last);
    while ($urandom_range(99) < msg_src_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= data;
    has_byte  <= has;
    last      <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Lowers valid and holds off until every outstanding digest has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_digests.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SEED_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr) sb.load_seed(wdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Programs the seed once the block has gone quiet, then reads it back.
  task automatic program_seed(input logic [31:0] value);
    logic [31:0] rd;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_access(1'b1, value, rd);
    @(negedge clk);
    apb_access(1'b0, '0, rd);
    if (rd !== value) sb.flag("seed readback", value, rd);
  endtask

  // Sends one message of the given length. It is closed either by marking
  // the final byte as last or by a separate closing transaction with no byte;
  // now and then an idle transaction is slipped in between the bytes.
  task automatic send_message(input int len, input bit close_apart);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !close_apart);
      items_sent++;
    end
    if (close_apart || len == 0) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int src_by_phase [NUM_PHASES];
    int sink_by_phase [NUM_PHASES];
    logic [31:0] seed_by_phase [NUM_PHASES];
    int len;
    int pick;
    int phase_start;

    src_by_phase  = '{0, 76, 0, 36};
    sink_by_phase = '{0, 0, 76, 36};
    seed_by_phase = '{32'hffff_ffff, $urandom(), 32'h0000_0000, $urandom()};

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, under the seed that reset leaves behind.
    // The empty message.
    send_item(8'h00, 1'b0, 1'b1);
    // An idle transaction, then a one-byte message with the byte on the last.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    // One whole tail word.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h5a, 1'b1, 1'b1);
    // Exactly one block, so the long start value with an empty tail.
    for (int i = 0; i < 16; i++) begin
      send_item((i % 2 == 0) ? 8'hff : 8'h00, 1'b1, i == 15);
    end

    // Random part, one phase per idling pattern, each under a fresh seed.
    for (int p = 0; p < NUM_PHASES; p++) begin
      // A message still in progress here is dropped by the seed write.
      program_seed(seed_by_phase[p]);
      src_pct  = src_by_phase[p];
      sink_pct = sink_by_phase[p];
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        // Most messages are short; a few span several blocks.
        pick = $urandom_range(99);
        if (pick < 10) begin
          len = 0;
        end else if (pick < 70) begin
          len = $urandom_range(20, 1);
        end else if (pick < 95) begin
          len = $urandom_range(48, 21);
        end else begin
          len = $urandom_range(80, 49);
        end
        // Roughly one message in four goes out without sender gaps.
        msg_src_pct = ($urandom_range(3) == 0) ? 0 : src_pct;
        send_message(len, 1'($urandom_range(1)));
        // Occasionally hold the sender until the result channel is empty.
        if ($urandom_range(19) == 0) drain_results();
      end
      // Leave a partial message behind for the next seed write to discard.
      len = $urandom_range(20, 1);
      for (int i = 0; i < len; i++) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        items_sent++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_digests.size() == 0) begin
      $display("xxhash32_stream_hasher_top test passed");
    end else begin
      $display("xxhash32_stream_hasher_top test failed");
    end
    $finish;
  end

endmodule
